/* sv/barometer_compensation_crc4_defines.svh */
// Assertion helpers shared by the checking code of this block.
`ifndef BAROMETER_COMPENSATION_CRC4_DEFINES_SVH
`define BAROMETER_COMPENSATION_CRC4_DEFINES_SVH

// Same-cycle implication.
`define BCC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bcc check failed");

// Next-cycle implication.
`define BCC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bcc check failed");

`endif

/* sv/bcc_pkg.sv */
`timescale 1ns / 1ps
package bcc_pkg;

    localparam int NumRegs  = 7;
    localparam int CfgIdxW  = 3;
    localparam int WordW    = 16;
    localparam int SampleW  = 24;
    localparam int ValueW   = 32;
    localparam int DiffW    = 26;
    localparam int MulAW    = 26;
    localparam int MulBW    = 20;
    localparam int ProdW    = MulAW + MulBW;
    localparam int SensW    = 38;
    localparam int AccW     = 62;
    localparam int CrcCntW  = 4;

    localparam int TempBase      = 2000;
    localparam int TempShift     = 23;
    localparam int SensProdShift = 21;
    localparam int PressShift    = 15;
    localparam int OffShift      = 6;
    localparam int SensShift     = 7;
    localparam int SensSplit     = 19;

    localparam logic [WordW-1:0] CrcPoly       = 16'h3000;
    localparam logic [WordW-1:0] Word0Mask     = 16'h0FFF;
    localparam logic [WordW-1:0] CrcNibbleMask = 16'hF000;

    // Calibration register indexes
    localparam logic [CfgIdxW-1:0] RegFactory   = 3'd0;
    localparam logic [CfgIdxW-1:0] RegSens      = 3'd1;
    localparam logic [CfgIdxW-1:0] RegOff       = 3'd2;
    localparam logic [CfgIdxW-1:0] RegSensTemp  = 3'd3;
    localparam logic [CfgIdxW-1:0] RegOffTemp   = 3'd4;
    localparam logic [CfgIdxW-1:0] RegRefTemp   = 3'd5;
    localparam logic [CfgIdxW-1:0] RegTempSlope = 3'd6;
    localparam logic [CfgIdxW-1:0] RegPad       = 3'd7;

    typedef logic [WordW-1:0] word_t;
    typedef word_t [NumRegs-1:0] cal_t;

    typedef struct packed {
        logic                    en;
        logic signed [MulAW-1:0] a;
        logic signed [MulBW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic done;
        logic match;
    } crc_stat_t;

endpackage

/* sv/bcc_mul.sv */
`timescale 1ns / 1ps
// Shared signed multiplier, registered product.
module bcc_mul (
    input  logic                                 aclk,
    input  bcc_pkg::mul_req_t                    req,
    output logic signed [bcc_pkg::ProdW-1:0]     prod
);
    localparam int ProdW = bcc_pkg::ProdW;
    localparam int MulAW = bcc_pkg::MulAW;
    localparam int MulBW = bcc_pkg::MulBW;

    logic signed [ProdW-1:0] a_ext;
    logic signed [ProdW-1:0] b_ext;
    logic signed [ProdW-1:0] prod_reg;

    assign a_ext = $signed({{(ProdW-MulAW){req.a[MulAW-1]}}, req.a});
    assign b_ext = $signed({{(ProdW-MulBW){req.b[MulBW-1]}}, req.b});

    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= a_ext * b_ext;
        end
    end

    assign prod = prod_reg;

endmodule

/* sv/bcc_crc.sv */
`timescale 1ns / 1ps
// CRC4 over the calibration words, one byte per cycle.
module bcc_crc (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  bcc_pkg::cal_t       cal,
    output bcc_pkg::crc_stat_t  stat
);
    localparam int WordW   = bcc_pkg::WordW;
    localparam int CrcCntW = bcc_pkg::CrcCntW;

    logic [CrcCntW-1:0] cnt_reg;
    logic               busy_reg;
    logic               match_reg;
    logic [WordW-1:0]   rem_reg;
    logic [WordW-1:0]   rem_next;
    logic [WordW-1:0]   word;
    logic [7:0]         byte_v;
    logic [2:0]         widx;

    assign widx = cnt_reg[CrcCntW-1:1];

    always_comb begin
        word = '0;
        if (widx != bcc_pkg::RegPad) begin
            word = cal[widx];
        end
        if (widx == bcc_pkg::RegFactory) begin
            word = word & bcc_pkg::Word0Mask;
        end
        byte_v   = cnt_reg[0] ? word[7:0] : word[WordW-1:8];
        rem_next = rem_reg ^ {8'd0, byte_v};
        for (int b = 0; b < 8; b++) begin
            if (rem_next[WordW-1]) begin
                rem_next = {rem_next[WordW-2:0], 1'b0} ^ bcc_pkg::CrcPoly;
            end else begin
                rem_next = {rem_next[WordW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            match_reg <= 1'b0;
            rem_reg   <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == '1) begin
                busy_reg  <= 1'b0;
                match_reg <= (rem_next & bcc_pkg::CrcNibbleMask) ==
                             (cal[bcc_pkg::RegFactory] & bcc_pkg::CrcNibbleMask);
            end
        end
    end

    assign stat.done  = !busy_reg;
    assign stat.match = match_reg;

endmodule

/* sv/barometer_compensation_crc4.sv */
`timescale 1ns / 1ps
// Barometer first-order compensation with calibration CRC4 check.
// Input channel s_*: s_action (0 temperature, 1 pressure) and a 24-bit raw
// sample. Each input transaction yields exactly one result transaction on m_*:
// kind, signed 32-bit value, saturated flag and calibration_ok.
// Calibration words are written on cfg_* (index 0..6, others ignored); the
// port is always ready, and writes are expected only while the block is idle.
// A temperature transaction stores the temperature difference used by later
// pressure transactions; pressure before any temperature uses zero.
// The CRC4 engine walks the 16 calibration bytes one per cycle, and it sets
// the pace: a result is registered once the CRC is done, and s_ready returns
// at that same edge, so an item is accepted only after the last one is done.
// Arithmetic runs beside the CRC through a single 26x20 multiplier (one
// product for temperature, four for pressure).
// s_ready is high only while the sequencer idles. A finished result sits in
// the output register; if the receiver stalls, the next item still runs and
// holds in its final step until the output register frees up.
// Reset (aresetn low, synchronous) clears calibration words, the stored
// temperature difference and all handshake state.
`include "barometer_compensation_crc4_defines.svh"

module barometer_compensation_crc4 (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_action,
    input  logic [bcc_pkg::SampleW-1:0]           s_raw_sample,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_kind,
    output logic signed [bcc_pkg::ValueW-1:0]     m_value,
    output logic                                  m_saturated,
    output logic                                  m_calibration_ok,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bcc_pkg::CfgIdxW-1:0]           cfg_index,
    input  logic [bcc_pkg::WordW-1:0]             cfg_data
);
    localparam int SampleW = bcc_pkg::SampleW;
    localparam int ValueW  = bcc_pkg::ValueW;
    localparam int DiffW   = bcc_pkg::DiffW;
    localparam int ProdW   = bcc_pkg::ProdW;
    localparam int SensW   = bcc_pkg::SensW;
    localparam int AccW    = bcc_pkg::AccW;
    localparam int CfgIdxW = bcc_pkg::CfgIdxW;
    localparam int SensSplit = bcc_pkg::SensSplit;

    localparam logic signed [AccW-1:0] TempBaseAcc = AccW'(bcc_pkg::TempBase);
    localparam logic signed [AccW-1:0] SatMax =
        {{(AccW-ValueW+1){1'b0}}, {(ValueW-1){1'b1}}};
    localparam logic signed [AccW-1:0] SatMin =
        {{(AccW-ValueW+1){1'b1}}, {(ValueW-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_DIFF,
        ST_T_MUL,
        ST_T_SUM,
        ST_P_MUL_OFF,
        ST_P_OFF,
        ST_P_MUL_SENS,
        ST_P_SENS,
        ST_P_MUL_LO,
        ST_P_LO,
        ST_P_MUL_HI,
        ST_P_HI,
        ST_P_SUB,
        ST_P_SHIFT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    bcc_pkg::cal_t            cal_reg;
    logic signed [DiffW-1:0]  dt_reg;
    logic [SampleW-1:0]       raw_reg;
    logic                     kind_reg;
    logic signed [SensW-1:0]  off_reg;
    logic signed [SensW-1:0]  sens_reg;
    logic signed [AccW-1:0]   acc_reg;

    logic                     m_valid_reg;
    logic                     m_kind_reg;
    logic signed [ValueW-1:0] m_value_reg;
    logic                     m_saturated_reg;
    logic                     m_calibration_ok_reg;

    bcc_pkg::mul_req_t        mul_req;
    logic signed [ProdW-1:0]  prod;
    bcc_pkg::crc_stat_t       crc_stat;

    logic                     in_fire;
    logic                     out_free;
    logic                     result_load;

    // Datapath terms
    logic signed [ProdW-1:0]  prod_off_shr;
    logic signed [ProdW-1:0]  prod_sens_shr;
    logic signed [AccW-1:0]   prod_ext;
    logic signed [SensW-1:0]  off_next;
    logic signed [SensW-1:0]  sens_next;
    logic signed [DiffW-1:0]  dt_next;
    logic signed [AccW-1:0]   off_ext;
    logic                     sat_hi;
    logic                     sat_lo;

    assign in_fire     = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign result_load = (state_reg == ST_FINISH) && crc_stat.done && out_free;
    assign s_ready     = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;

    // Shared multiplier
    bcc_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    // CRC4 engine, restarted for every item
    bcc_crc u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_fire),
        .cal     (cal_reg),
        .stat    (crc_stat)
    );

    assign prod_ext      = $signed({{(AccW-ProdW){prod[ProdW-1]}}, prod});
    assign prod_off_shr  = prod >>> bcc_pkg::OffShift;
    assign prod_sens_shr = prod >>> bcc_pkg::SensShift;

    // OFF = C2*2^17 + (C4*dT)/2^6, SENS = C1*2^16 + (C3*dT)/2^7
    assign off_next  = $signed({5'd0, cal_reg[bcc_pkg::RegOff], 17'd0}) +
                       $signed(prod_off_shr[SensW-1:0]);
    assign sens_next = $signed({6'd0, cal_reg[bcc_pkg::RegSens], 16'd0}) +
                       $signed(prod_sens_shr[SensW-1:0]);
    assign dt_next   = $signed({2'd0, raw_reg}) -
                       $signed({2'd0, cal_reg[bcc_pkg::RegRefTemp], 8'd0});
    assign off_ext   = $signed({{(AccW-SensW){off_reg[SensW-1]}}, off_reg});

    assign sat_hi = (acc_reg > SatMax);
    assign sat_lo = (acc_reg < SatMin);

    // Multiplier operand select; raw*SENS is split into low and high halves
    always_comb begin
        mul_req.en = 1'b0;
        mul_req.a  = dt_reg;
        mul_req.b  = $signed({4'd0, cal_reg[bcc_pkg::RegTempSlope]});
        case (state_reg)
            ST_T_MUL: begin
                mul_req.en = 1'b1;
            end
            ST_P_MUL_OFF: begin
                mul_req.en = 1'b1;
                mul_req.b  = $signed({4'd0, cal_reg[bcc_pkg::RegOffTemp]});
            end
            ST_P_MUL_SENS: begin
                mul_req.en = 1'b1;
                mul_req.b  = $signed({4'd0, cal_reg[bcc_pkg::RegSensTemp]});
            end
            ST_P_MUL_LO: begin
                mul_req.en = 1'b1;
                mul_req.a  = $signed({2'd0, raw_reg});
                mul_req.b  = $signed({1'b0, sens_reg[SensSplit-1:0]});
            end
            ST_P_MUL_HI: begin
                mul_req.en = 1'b1;
                mul_req.a  = $signed({2'd0, raw_reg});
                mul_req.b  = $signed({sens_reg[SensW-1], sens_reg[SensW-1:SensSplit]});
            end
            default: begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = s_action ? ST_P_MUL_OFF : ST_T_DIFF;
                end
            end
            ST_T_DIFF:     state_next = ST_T_MUL;
            ST_T_MUL:      state_next = ST_T_SUM;
            ST_T_SUM:      state_next = ST_FINISH;
            ST_P_MUL_OFF:  state_next = ST_P_OFF;
            ST_P_OFF:      state_next = ST_P_MUL_SENS;
            ST_P_MUL_SENS: state_next = ST_P_SENS;
            ST_P_SENS:     state_next = ST_P_MUL_LO;
            ST_P_MUL_LO:   state_next = ST_P_LO;
            ST_P_LO:       state_next = ST_P_MUL_HI;
            ST_P_MUL_HI:   state_next = ST_P_HI;
            ST_P_HI:       state_next = ST_P_SUB;
            ST_P_SUB:      state_next = ST_P_SHIFT;
            ST_P_SHIFT:    state_next = ST_FINISH;
            ST_FINISH: begin
                if (crc_stat.done && out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cal_reg     <= '0;
            dt_reg      <= '0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready && (cfg_index < CfgIdxW'(bcc_pkg::NumRegs))) begin
                cal_reg[cfg_index] <= cfg_data;
            end

            // a new result may replace one leaving at the same edge
            if (result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        raw_reg  <= s_raw_sample;
                        kind_reg <= s_action;
                    end
                end
                ST_T_DIFF:  dt_reg   <= dt_next;
                ST_T_SUM:   acc_reg  <= TempBaseAcc + (prod_ext >>> bcc_pkg::TempShift);
                ST_P_OFF:   off_reg  <= off_next;
                ST_P_SENS:  sens_reg <= sens_next;
                ST_P_LO:    acc_reg  <= prod_ext;
                ST_P_HI:    acc_reg  <= acc_reg + (prod_ext <<< SensSplit);
                ST_P_SUB:   acc_reg  <= (acc_reg >>> bcc_pkg::SensProdShift) - off_ext;
                ST_P_SHIFT: acc_reg  <= acc_reg >>> bcc_pkg::PressShift;
                ST_FINISH: begin
                    if (result_load) begin
                        m_kind_reg           <= kind_reg;
                        m_saturated_reg      <= sat_hi || sat_lo;
                        m_calibration_ok_reg <= crc_stat.match;
                        if (sat_hi) begin
                            m_value_reg <= SatMax[ValueW-1:0];
                        end else if (sat_lo) begin
                            m_value_reg <= SatMin[ValueW-1:0];
                        end else begin
                            m_value_reg <= acc_reg[ValueW-1:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = m_kind_reg;
    assign m_value          = m_value_reg;
    assign m_saturated      = m_saturated_reg;
    assign m_calibration_ok = m_calibration_ok_reg;

    // Checks
    `BCC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `BCC_ASSERT_IMPL(a_temp_never_clips, aclk, aresetn, m_valid && !m_kind, !m_saturated)
    `BCC_ASSERT_IMPL(a_clip_at_limit, aclk, aresetn, m_valid && m_saturated,
        (m_value == 32'sh7FFF_FFFF) || (m_value == 32'sh8000_0000))
    `BCC_ASSERT_IMPL(a_result_after_crc, aclk, aresetn, $rose(m_valid), crc_stat.done)

endmodule

/* tb/bcc_result_checker.sv */
`timescale 1ns / 1ps
package bcc_tb_pkg;
    import bcc_pkg::*;

    // CRC4 over words 0..6 and a zero pad word; the stored nibble of word 0 is masked off.
    function automatic logic [3:0] calib_crc4(cal_t words);
        logic [WordW-1:0] rem;
        logic [WordW-1:0] w;
        logic [7:0]       octet;
        rem = '0;
        for (int i = 0; i < 16; i++) begin
            w = '0;
            if (i / 2 < NumRegs) w = words[i / 2];
            if (i / 2 == 0) w = w & Word0Mask;
            octet = (i % 2 == 1) ? w[7:0] : w[15:8];
            rem = rem ^ {8'h00, octet};
            for (int b = 0; b < 8; b++) begin
                if (rem[15]) rem = (rem << 1) ^ CrcPoly;
                else rem = rem << 1;
            end
        end
        return rem[15:12];
    endfunction
endpackage

module bcc_result_checker
    import bcc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_action,
    input  logic [SampleW-1:0]       s_raw_sample,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic                     m_kind,
    input  logic signed [ValueW-1:0] m_value,
    input  logic                     m_saturated,
    input  logic                     m_calibration_ok,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CfgIdxW-1:0]       cfg_index,
    input  logic [WordW-1:0]         cfg_data,
    output int                       mismatches,
    output int                       outstanding,
    output int                       readings_checked
);

    typedef struct packed {
        logic                     kind;
        logic signed [ValueW-1:0] value;
        logic                     saturated;
        logic                     calibration_ok;
    } reading_t;

    localparam longint ValueMax = 64'sd2147483647;
    localparam longint ValueMin = -64'sd2147483648;

    cal_t                    cal_words;
    logic signed [DiffW-1:0] held_dt;
    reading_t                expected_readings[$];
    int                      err_tally;
    int                      checked_tally;

    initial begin
        mismatches       = 0;
        outstanding      = 0;
        readings_checked = 0;
        err_tally        = 0;
        checked_tally    = 0;
    end

    // First-order compensation; dt is the fresh difference for temperature,
    // the held one for pressure. Shifts on signed longint are floor shifts.
    function automatic reading_t reading_for(logic action, logic [SampleW-1:0] raw,
                                             logic signed [DiffW-1:0] dt, cal_t c);
        reading_t r;
        longint   raw_l;
        longint   dt_l;
        longint   off;
        longint   sens;
        longint   res;
        raw_l = {40'd0, raw};
        dt_l  = longint'(dt);
        if (!action) begin
            res = TempBase + ((dt_l * longint'({48'd0, c[RegTempSlope]})) >>> TempShift);
        end else begin
            off  = (longint'({48'd0, c[RegOff]}) <<< 17)
                 + ((longint'({48'd0, c[RegOffTemp]}) * dt_l) >>> OffShift);
            sens = (longint'({48'd0, c[RegSens]}) <<< 16)
                 + ((longint'({48'd0, c[RegSensTemp]}) * dt_l) >>> SensShift);
            res  = (((raw_l * sens) >>> SensProdShift) - off) >>> PressShift;
        end
        r.saturated = 1'b0;
        if (res > ValueMax) begin
            res = ValueMax;
            r.saturated = 1'b1;
        end else if (res < ValueMin) begin
            res = ValueMin;
            r.saturated = 1'b1;
        end
        r.kind           = action;
        r.value          = res[ValueW-1:0];
        r.calibration_ok = (bcc_tb_pkg::calib_crc4(c) == c[RegFactory][15:12]);
        return r;
    endfunction

    always @(posedge aclk) begin
        reading_t                want;
        reading_t                got;
        logic signed [DiffW-1:0] dt_now;
        if (!aresetn) begin
            cal_words <= '0;
            held_dt   <= '0;
            expected_readings.delete();
        end else begin
            // results first: a result at the same edge as a new input is an older one
            if (m_valid && m_ready) begin
                got = '{m_kind, m_value, m_saturated, m_calibration_ok};
                checked_tally++;
                if (expected_readings.size() == 0) begin
                    err_tally++;
                    $display("%0t ns: unexpected result kind=%0d value=%0d sat=%0d cal_ok=%0d",
                             $time, got.kind, got.value, got.saturated, got.calibration_ok);
                end else begin
                    want = expected_readings.pop_front();
                    if (got.kind !== want.kind || got.value !== want.value ||
                        got.saturated !== want.saturated ||
                        got.calibration_ok !== want.calibration_ok) begin
                        err_tally++;
                        $display("%0t ns: mismatch expected kind=%0d value=%0d sat=%0d cal_ok=%0d",
                                 $time, want.kind, want.value, want.saturated,
                                 want.calibration_ok);
                        $display("%0t ns:          actual kind=%0d value=%0d sat=%0d cal_ok=%0d",
                                 $time, got.kind, got.value, got.saturated, got.calibration_ok);
                    end
                end
            end
            if (s_valid && s_ready) begin
                dt_now = s_action ? held_dt :
                         $signed({2'b00, s_raw_sample}) -
                         $signed({2'b00, cal_words[RegRefTemp], 8'h00});
                if (!s_action) held_dt <= dt_now;
                expected_readings.push_back(reading_for(s_action, s_raw_sample, dt_now,
                                                        cal_words));
            end
            // the sender is to make writes only while idle; nothing here enforces it; the pad index is dropped
            if (cfg_valid && cfg_ready && cfg_index != RegPad)
                cal_words[cfg_index] <= cfg_data;
        end
        mismatches       <= err_tally;
        outstanding      <= expected_readings.size();
        readings_checked <= checked_tally;
    end

endmodule

/* tb/tb_barometer_compensation_crc4.sv */
`timescale 1ns / 1ps
// Stimulus and verdict only; prediction and comparison live in bcc_result_checker.
module tb_barometer_compensation_crc4;
    import bcc_pkg::*;

    // Slowest legal run: ~520 items, each with the longest sender gap and result
    // stall, plus drains. Taken ~8x over.
    localparam int CycleLimit  = 400000;
    // Result registers once the CRC is done after acceptance; s_ready back at that edge.
    localparam int SettleCycles = 24;
    localparam int RandomPhases = 5;
    localparam int PhaseItems   = 100;

    logic                     aclk             = 1'b0;
    logic                     aresetn          = 1'b0;
    logic                     s_valid          = 1'b0;
    logic                     s_ready;
    logic                     s_action         = 1'b0;
    logic [SampleW-1:0]       s_raw_sample     = '0;
    logic                     m_valid;
    logic                     m_ready          = 1'b0;
    logic                     m_kind;
    logic signed [ValueW-1:0] m_value;
    logic                     m_saturated;
    logic                     m_calibration_ok;
    logic                     cfg_valid        = 1'b0;
    logic                     cfg_ready;
    logic [CfgIdxW-1:0]       cfg_index        = '0;
    logic [WordW-1:0]         cfg_data         = '0;

    int   mismatches;
    int   outstanding;
    int   readings_checked;

    // steady_flow turns off idling on both sides for one random phase
    logic steady_flow = 1'b0;
    int   cycle_count = 0;
    int   temps_sent  = 0;
    int   press_sent  = 0;
    int   cal_loads   = 0;

    always #6 aclk = ~aclk;

    barometer_compensation_crc4 dut (.*);

    bcc_result_checker u_check (.*);

    // Watchdog: any hang ends the run as a failure.
    initial begin : watchdog
        while (cycle_count < CycleLimit) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
        $display("tb_barometer_compensation_crc4 failed");
        $finish;
    end

    // Result side: ~25% stalled cycles, mostly short, now and then a long
    // stall so the block's output register backs up behind the next item.
    initial begin : result_sink
        int hold;
        forever begin
            @(posedge aclk);
            if (steady_flow || $urandom_range(0, 99) >= 12) begin
                m_ready <= 1'b1;
            end else begin
                hold = ($urandom_range(0, 49) == 0) ? $urandom_range(20, 40) :
                                                      $urandom_range(1, 3);
                m_ready <= 1'b0;
                repeat (hold - 1) @(posedge aclk);
            end
        end
    end

    // One input transaction. A random gap before valid rises lands on every
    // phase of the block's item; valid stays up across back-to-back items, so
    // it is never lowered and raised in one step.
    task automatic send_sample(input logic act, input logic [SampleW-1:0] raw);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(0, 99) < 25) gap = $urandom_range(1, 24);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_raw_sample <= raw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (act) press_sent++;
        else temps_sent++;
    endtask

    // Stop sending and wait out every expected result.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // All seven words, then a write to the unused index that must be dropped.
    task automatic load_calibration(input cal_t words);
        for (int k = 0; k < NumRegs; k++) cfg_write(CfgIdxW'(k), words[k]);
        cfg_write(RegPad, WordW'($urandom));
        cfg_valid <= 1'b0;
        @(posedge aclk);
        cal_loads++;
    endtask

    // Temperature: full range, extremes, or close to the reference point.
    // Pressure: full range, extremes, or the usual operating band.
    function automatic logic [SampleW-1:0] draw_sample(input logic is_press,
                                                       input logic [WordW-1:0] ref_word);
        int pick;
        int v;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        if (!is_press && pick < 5) begin
            v = int'({8'd0, ref_word, 8'd0}) + int'($urandom_range(0, 8191)) - 4096;
            if (v < 0) v = 0;
            if (v > 16777215) v = 16777215;
            return SampleW'(v);
        end
        if (is_press && pick < 4) return SampleW'($urandom_range(3000000, 9000000));
        return SampleW'($urandom);
    endfunction

    initial begin : stimulus
        cal_t words;
        int   sent;
        int   burst;
        logic act;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset calibration (all zero, CRC of zeros matches): pressure before
        // any temperature uses the zero difference.
        send_sample(1'b1, '1);
        send_sample(1'b0, '0);
        send_sample(1'b1, 24'd6465444);
        drain_results();

        // Typical calibration set with a correct CRC nibble.
        words = '{16'd28165, 16'd31553, 16'd27842, 16'd29059, 16'd43981, 16'd46372,
                  16'h0A5C};
        words[RegFactory][15:12] = bcc_tb_pkg::calib_crc4(words);
        load_calibration(words);
        send_sample(1'b0, {words[RegRefTemp], 8'h00});  // zero difference
        send_sample(1'b1, '0);
        send_sample(1'b1, '1);
        send_sample(1'b0, '0);                          // large negative difference
        send_sample(1'b1, 24'd8077636);
        send_sample(1'b0, '1);                          // large positive difference
        send_sample(1'b1, '1);
        send_sample(1'b1, '0);
        send_sample(1'b0, 24'd8569150);
        send_sample(1'b1, 24'd6465444);
        drain_results();

        // Every coefficient at its maximum: widest products, negative sensitivity
        // terms and coldest reading; the CRC nibble is whatever 0xF gives.
        words = '1;
        load_calibration(words);
        send_sample(1'b0, '0);
        send_sample(1'b1, '1);
        send_sample(1'b1, '0);
        send_sample(1'b0, '1);
        send_sample(1'b1, '1);
        send_sample(1'b1, '0);
        drain_results();

        // Random phases: fresh calibration each (words forced to the extremes
        // now and then, half with a valid CRC), mostly a temperature followed by
        // a burst of pressures, the rest single items in any order.
        for (int phase = 0; phase < RandomPhases; phase++) begin
            for (int k = 0; k < NumRegs; k++) begin
                case ($urandom_range(0, 7))
                    0:       words[k] = '0;
                    1:       words[k] = '1;
                    default: words[k] = WordW'($urandom);
                endcase
            end
            if ($urandom_range(0, 1) == 1)
                words[RegFactory][15:12] = bcc_tb_pkg::calib_crc4(words);
            load_calibration(words);
            steady_flow <= (phase == 1);
            sent = 0;
            while (sent < PhaseItems) begin
                // halfway through, the sender holds off until all results are in
                if (sent >= PhaseItems / 2 && sent < PhaseItems / 2 + 5) begin
                    drain_results();
                    sent = sent + 5;
                end
                if ($urandom_range(0, 9) < 7) begin
                    send_sample(1'b0, draw_sample(1'b0, words[RegRefTemp]));
                    burst = $urandom_range(1, 4);
                    repeat (burst) send_sample(1'b1, draw_sample(1'b1, words[RegRefTemp]));
                    sent = sent + burst + 1;
                end else begin
                    act = 1'($urandom_range(0, 1));
                    send_sample(act, draw_sample(act, words[RegRefTemp]));
                    sent++;
                end
            end
            drain_results();
            steady_flow <= 1'b0;
        end

        // Everything accepted; wait out stragglers and any stray result.
        drain_results();
        repeat (SettleCycles) @(posedge aclk);

        $display("run covered %0d temperature and %0d pressure transactions, %0d calibration loads",
                 temps_sent, press_sent, cal_loads);
        $display("%0d results compared, %0d mismatching", readings_checked, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_barometer_compensation_crc4 passed");
        end else begin
            $display("tb_barometer_compensation_crc4 failed");
        end
        $finish;
    end

endmodule
